// File: rtl/bitmap_page_frame_allocator_defines.svh
// Assertion macros shared by the page frame allocator RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define BPFA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpfa: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define BPFA_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpfa: next-cycle check failed");

`endif

// File: rtl/bpfa_pkg.sv
// Shared types and constants of the page frame allocator.
// Depends on nothing; used by bpfa_bit_unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bpfa_pkg;

   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;
   localparam int FUNC_W    = 2;
   localparam int ADDR_W    = 48;
   localparam int PA_W      = 24;
   localparam int STAT_W    = 2;

   // request kinds
   localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REGION = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   // operands of the shared bit unit
   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [BIT_W-1:0]     lo;
      logic [BIT_W-1:0]     hi;
   } unit_in_type;

   // results of the shared bit unit
   typedef struct packed {
      logic [WORD_BITS-1:0] span_word;
      logic [WORD_BITS-1:0] take_word;
      logic [BIT_W-1:0]     low_bit;
      logic                 any;
   } unit_out_type;

endpackage

`default_nettype wire

// File: rtl/bpfa_map_ram.sv
// Free-page bitmap store: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_map_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [63:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [63:0]   rd_data
);

   logic [63:0] mem [DEPTH];

   // write one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read one word, data valid the next cycle; hold it otherwise
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/bpfa_bit_unit.sv
// Shared bit unit: sets a bit span in a map word, or takes its lowest set bit.
// Depends on bpfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_bit_unit (
   input  wire bpfa_pkg::unit_in_type  unit_in,
   output bpfa_pkg::unit_out_type      unit_out
);

   logic [63:0] lo_mask;
   logic [63:0] hi_mask;
   logic [63:0] low_one;
   logic [5:0]  low_idx;

   // span mask from bit lo up to bit hi
   assign lo_mask = {64{1'b1}} << unit_in.lo;
   assign hi_mask = {64{1'b1}} >> (6'd63 - unit_in.hi);

   // isolate the lowest set bit with one wide add
   assign low_one = unit_in.word & (~unit_in.word + 64'd1);

   // encode the one-hot lowest bit into its index
   always_comb begin
      low_idx = '0;
      for (int i = 0; i < 64; i++) begin
         if (low_one[i]) begin
            low_idx = low_idx | 6'(i);
         end
      end
   end

   assign unit_out.span_word = unit_in.word | (lo_mask & hi_mask);
   assign unit_out.take_word = unit_in.word & ~low_one;
   assign unit_out.low_bit   = low_idx;
   assign unit_out.any       = |unit_in.word;

endmodule

`default_nettype wire

// File: rtl/bitmap_page_frame_allocator.sv
// First-fit bitmap page frame allocator, one bit per page, 1 = free.
// Alloc: scans map words in order and takes the lowest free bit of the first word with one.
// Free and add region: each map word touched is read, then written back.
// Mark all used: one map word per cycle. One request at a time.
// Reset sweeps the map to all used, busy high meanwhile.
// Results come as a one-cycle rsp_valid strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_page_frame_allocator_defines.svh"

module bitmap_page_frame_allocator #(
   parameter int PAGE_COUNT = 4096,
   parameter int PAGE_BYTES = 4096   // power of two
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [47:0] req_address,
   input  wire logic [47:0] req_region_length,
   input  wire logic        req_region_usable,
   output logic             rsp_valid,
   output logic [23:0]      rsp_page_address,
   output logic [1:0]       rsp_status
);

   localparam int MAP_WORDS = (PAGE_COUNT + 63) / 64;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CW        = $clog2(MAP_WORDS + 1);
   localparam int PW        = $clog2(PAGE_COUNT);
   localparam int PSHIFT    = $clog2(PAGE_BYTES);
   localparam int FW        = bpfa_pkg::ADDR_W - PSHIFT;
   localparam int LW        = bpfa_pkg::ADDR_W + 1 - PSHIFT;
   localparam int IW        = AW + bpfa_pkg::BIT_W;
   localparam int PAW       = IW + PSHIFT;

   localparam logic [FW-1:0] NP_F      = FW'(PAGE_COUNT);
   localparam logic [LW-1:0] NP_L      = LW'(PAGE_COUNT);
   localparam logic [PW-1:0] TOP_PAGE  = PW'(PAGE_COUNT - 1);
   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
   localparam logic [CW-1:0] WORDS_C   = CW'(MAP_WORDS);
   localparam logic [IW:0]   NP_I      = (IW + 1)'(PAGE_COUNT);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_WR   = 3'd3;
   localparam logic [2:0] S_SCAN = 3'd4;
   localparam logic [2:0] S_CLR  = 3'd5;

   logic [2:0]                          state_ff, state_in;
   logic                                silent_ff, silent_in;
   logic [bpfa_pkg::FUNC_W-1:0]         func_ff, func_in;
   logic [47:0]                         addr_ff, addr_in;
   logic [47:0]                         len_ff, len_in;
   logic                                usable_ff, usable_in;
   logic [PW-1:0]                       first_ff, first_in;
   logic [PW-1:0]                       last_ff, last_in;
   logic [AW-1:0]                       cur_ff, cur_in;
   logic [CW-1:0]                       scan_ff, scan_in;
   logic                                rv_ff, rv_in;
   logic [AW-1:0]                       rw_ff, rw_in;
   logic [bpfa_pkg::STAT_W-1:0]         st_ff, st_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [bpfa_pkg::PA_W-1:0]           rsp_addr_ff, rsp_addr_in;
   logic [bpfa_pkg::STAT_W-1:0]         rsp_status_ff, rsp_status_in;

   logic          ram_we;
   logic [AW-1:0] ram_wa;
   logic [63:0]   ram_wd;
   logic          ram_re;
   logic [AW-1:0] ram_ra;
   logic [63:0]   ram_rd;

   bpfa_pkg::unit_in_type  unit_in;
   bpfa_pkg::unit_out_type unit_out;

   logic          accept;
   logic [FW-1:0] first_full;
   logic [48:0]   end_byte;
   logic [LW-1:0] last_full;
   logic [AW-1:0] w0;
   logic [AW-1:0] w1;
   logic [IW-1:0] hit_idx;
   logic [PAW-1:0] hit_bytes;

   bpfa_map_ram #(
      .DEPTH (MAP_WORDS),
      .AW    (AW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   bpfa_bit_unit u_bit_unit (
      .unit_in  (unit_in),
      .unit_out (unit_out)
   );

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // page span of the held request
   assign first_full = addr_ff[47:PSHIFT];
   assign end_byte   = {1'b0, addr_ff} + {1'b0, len_ff} - 49'd1;
   assign last_full  = end_byte[48:PSHIFT];
   assign w0         = AW'(first_ff >> bpfa_pkg::BIT_W);
   assign w1         = AW'(last_ff >> bpfa_pkg::BIT_W);

   // page hit of the scan
   assign hit_idx   = {rw_ff, unit_out.low_bit};
   assign hit_bytes = PAW'(hit_idx) << PSHIFT;

   // feed the shared unit with the word just read and the span limits
   always_comb begin
      unit_in.word = ram_rd;
      unit_in.lo   = (cur_ff == w0) ? first_ff[5:0] : 6'd0;
      unit_in.hi   = (cur_ff == w1) ? last_ff[5:0] : 6'd63;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      silent_in     = silent_ff;
      func_in       = func_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      usable_in     = usable_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      cur_in        = cur_ff;
      scan_in       = scan_ff;
      rv_in         = 1'b0;
      rw_in         = rw_ff;
      st_in         = st_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = '0;
      rsp_status_in = bpfa_pkg::ST_OK;
      ram_we        = 1'b0;
      ram_wa        = cur_ff;
      ram_wd        = '0;
      ram_re        = 1'b0;
      ram_ra        = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in   = req_func;
               addr_in   = req_address;
               len_in    = req_region_length;
               usable_in = req_region_usable;
               cur_in    = '0;
               scan_in   = '0;
               silent_in = 1'b0;
               case (req_func)
                  bpfa_pkg::FUNC_ALLOC: state_in = S_SCAN;
                  bpfa_pkg::FUNC_CLEAR: state_in = S_CLR;
                  default:              state_in = S_PREP;
               endcase
            end
         end

         // resolve the page span and range of a free or add region request
         S_PREP: begin
            st_in = bpfa_pkg::ST_OK;
            if (func_ff == bpfa_pkg::FUNC_FREE) begin
               if (first_full >= NP_F) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = bpfa_pkg::ST_RANGE;
                  state_in      = S_IDLE;
               end else begin
                  first_in = PW'(first_full);
                  last_in  = PW'(first_full);
                  cur_in   = AW'(first_full >> bpfa_pkg::BIT_W);
                  state_in = S_RD;
               end
            end else if (!usable_ff || (len_ff == '0)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (first_full >= NP_F) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bpfa_pkg::ST_RANGE;
               state_in      = S_IDLE;
            end else begin
               first_in = PW'(first_full);
               cur_in   = AW'(first_full >> bpfa_pkg::BIT_W);
               if (last_full >= NP_L) begin
                  last_in = TOP_PAGE;
                  st_in   = bpfa_pkg::ST_RANGE;
               end else begin
                  last_in = PW'(last_full);
               end
               state_in = S_RD;
            end
         end

         // read the next word of the span
         S_RD: begin
            ram_re   = 1'b1;
            ram_ra   = cur_ff;
            state_in = S_WR;
         end

         // write it back with the span bits set; advance or finish
         S_WR: begin
            ram_we = 1'b1;
            ram_wa = cur_ff;
            ram_wd = unit_out.span_word;
            if (cur_ff == w1) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end else begin
               cur_in   = cur_ff + AW'(1);
               state_in = S_RD;
            end
         end

         // stream reads of the map; check each word as it arrives
         S_SCAN: begin
            if (scan_ff < WORDS_C) begin
               ram_re  = 1'b1;
               ram_ra  = scan_ff[AW-1:0];
               scan_in = scan_ff + CW'(1);
               rv_in   = 1'b1;
               rw_in   = scan_ff[AW-1:0];
            end
            if (rv_ff && unit_out.any) begin
               rv_in        = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if ({1'b0, hit_idx} >= NP_I) begin
                  rsp_status_in = bpfa_pkg::ST_NONE;
               end else begin
                  ram_we      = 1'b1;
                  ram_wa      = rw_ff;
                  ram_wd      = unit_out.take_word;
                  rsp_addr_in = bpfa_pkg::PA_W'(hit_bytes);
               end
            end else if (rv_ff && (rw_ff == LAST_WORD)) begin
               rv_in         = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = bpfa_pkg::ST_NONE;
               state_in      = S_IDLE;
            end
         end

         // sweep the map to all used
         S_CLR: begin
            ram_we = 1'b1;
            ram_wa = cur_ff;
            ram_wd = '0;
            if (cur_ff == LAST_WORD) begin
               rsp_valid_in = !silent_ff;
               state_in     = S_IDLE;
            end else begin
               cur_in = cur_ff + AW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         silent_ff    <= 1'b1;
         cur_ff       <= '0;
         scan_ff      <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         silent_ff    <= silent_in;
         cur_ff       <= cur_in;
         scan_ff      <= scan_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      usable_ff     <= usable_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      rw_ff         <= rw_in;
      st_ff         <= st_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;

   // a result shows only once the sequencer is back to idle
   `BPFA_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE)
   // an accepted request keeps the block busy in the next cycle
   `BPFA_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   // a failed result carries a zero page address
   `BPFA_ASSERT_IMP(a_rsp_addr_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff != bpfa_pkg::ST_OK), rsp_addr_ff == '0)
   // the map never reads and writes the same word in one cycle
   `BPFA_ASSERT_IMP(a_ram_no_clash, clock, reset, ram_we && ram_re, ram_wa != ram_ra)

endmodule

`default_nettype wire
